@@ rtl/core/bb3_pkg.sv @@
// ----------------------------------------------------------------------------
// bb3_pkg
// shared types, register indexes and the rounding divider of the 3x3 blur
// ----------------------------------------------------------------------------
package bb3_pkg;

  // register indexes of the configuration port
  localparam logic [0:0] REG_WIDTH  = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;

  // request codes
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  localparam int unsigned CFG_W_BITS = 11;
  localparam int unsigned CFG_H_BITS = 13;
  localparam logic [12:0] MAX_HEIGHT = 13'd4096;
  localparam logic [12:0] MIN_SIZE_H = 13'd2;

  // per item classification made by the front end
  typedef struct packed {
    logic emit;
    logic top;
    logic bottom;
    logic left;
    logic right;
    logic last;
  } bb3_flags_t;

  // status toward the checks in the top level
  typedef struct packed {
    logic [2:0] out_cnt;
    logic [1:0] inflight;
  } bb3_stat_t;

  // (sum + n/2) div n for n in {4, 6, 9}, reciprocal multiply
  function automatic logic [7:0] div_avg(input logic [11:0] sum, input logic rows3,
                                         input logic cols3);
    logic [11:0] x;
    logic [25:0] p;
    logic [7:0]  q;
    x = 12'd0;
    p = 26'd0;
    q = 8'd0;
    case ({rows3, cols3})
      2'b11: begin
        x = sum + 12'd4;
        p = 26'(x) * 26'd7282;
        q = p[23:16];
      end
      2'b00: begin
        x = sum + 12'd2;
        q = x[9:2];
      end
      default: begin
        x = sum + 12'd3;
        p = 26'(x) * 26'd10923;
        q = p[23:16];
      end
    endcase
    return q;
  endfunction

endpackage

@@ rtl/core/bb3_fifo.sv @@
// ----------------------------------------------------------------------------
// bb3_fifo
// small register queue with occupancy count
// ----------------------------------------------------------------------------
module bb3_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [W-1:0]               push_data,
  input  logic                       pop,
  output logic [W-1:0]               head,
  output logic [$clog2(DEPTH):0]     count
);
  localparam int unsigned AW = $clog2(DEPTH);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  assign head  = mem_r[rp_r];
  assign count = cnt_r;
endmodule

@@ rtl/core/bb3_front.sv @@
// ----------------------------------------------------------------------------
// bb3_front
// position counters and classification of each accepted item
// ----------------------------------------------------------------------------
module bb3_front #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [10:0]                    width_cfg,
  input  logic [12:0]                    height_cfg,
  input  logic                           accept,
  input  logic                           req_type,
  input  logic [23:0]                    pix_in,
  output logic                           push,
  output logic [23:0]                    pix_out,
  output logic [$clog2(MAX_WIDTH)-1:0]   idx_out,
  output bb3_pkg::bb3_flags_t            flags_out
);
  import bb3_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned CMPW = 14;

  logic [CW-1:0] icol_r, icol_nxt;
  logic [12:0]   irow_r, irow_nxt;
  logic [CW-1:0] ocol_r, ocol_nxt;
  logic [11:0]   orow_r, orow_nxt;

  logic [CMPW-1:0] w_ext, w_use, icol_p1, ocol_p1;
  logic [12:0]     h_use, orow_p1;
  logic            in_frame, drop;
  bb3_flags_t      fl;

  always_comb begin
    w_ext = CMPW'(width_cfg);
    if (w_ext < CMPW'(2)) w_use = CMPW'(2);
    else if (w_ext > CMPW'(MAX_WIDTH)) w_use = CMPW'(MAX_WIDTH);
    else w_use = w_ext;
    if (height_cfg < MIN_SIZE_H) h_use = MIN_SIZE_H;
    else if (height_cfg > MAX_HEIGHT) h_use = MAX_HEIGHT;
    else h_use = height_cfg;
  end

  always_comb begin
    icol_p1  = CMPW'(icol_r) + CMPW'(1);
    ocol_p1  = CMPW'(ocol_r) + CMPW'(1);
    orow_p1  = 13'(orow_r) + 13'd1;
    in_frame = irow_r < h_use;
    drop     = (req_type == REQ_DRAIN) && in_frame;
    push     = accept && !drop;
    pix_out  = ((req_type == REQ_PIXEL) && in_frame) ? pix_in : 24'd0;
    idx_out  = icol_r;
    fl.emit   = (irow_r >= 13'd2) || ((irow_r == 13'd1) && (icol_r != '0));
    fl.top    = orow_r != 12'd0;
    fl.bottom = orow_p1 < h_use;
    fl.left   = ocol_r != '0;
    fl.right  = ocol_p1 < w_use;
    fl.last   = (orow_p1 >= h_use) && (ocol_p1 >= w_use);
    flags_out = fl;

    icol_nxt = icol_r;
    irow_nxt = irow_r;
    ocol_nxt = ocol_r;
    orow_nxt = orow_r;
    if (push) begin
      if (icol_p1 >= w_use) begin
        icol_nxt = '0;
        irow_nxt = irow_r + 13'd1;
      end else begin
        icol_nxt = icol_p1[CW-1:0];
      end
      if (fl.emit) begin
        if (fl.last) begin
          icol_nxt = '0;
          irow_nxt = '0;
          ocol_nxt = '0;
          orow_nxt = '0;
        end else if (fl.right == 1'b0) begin
          ocol_nxt = '0;
          orow_nxt = orow_r + 12'd1;
        end else begin
          ocol_nxt = ocol_p1[CW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      icol_r <= '0;
      irow_r <= '0;
      ocol_r <= '0;
      orow_r <= '0;
    end else begin
      icol_r <= icol_nxt;
      irow_r <= irow_nxt;
      ocol_r <= ocol_nxt;
      orow_r <= orow_nxt;
    end
  end
endmodule

@@ rtl/core/bb3_back.sv @@
// ----------------------------------------------------------------------------
// bb3_back
// line stores, 3x3 window, masked sums, division and result queue
// ----------------------------------------------------------------------------
module bb3_back #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cmd_valid,
  input  logic [23:0]                    cmd_pix,
  input  logic [$clog2(MAX_WIDTH)-1:0]   cmd_idx,
  input  bb3_pkg::bb3_flags_t            cmd_flags,
  output logic                           cmd_pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_red,
  output logic [7:0]                     out_green,
  output logic [7:0]                     out_blue,
  output logic                           out_last,
  output bb3_pkg::bb3_stat_t             stat
);
  import bb3_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned OUT_DEPTH = 4;

  logic [23:0] mem_up [MAX_WIDTH];
  logic [23:0] mem_lo [MAX_WIDTH];
  logic [23:0] rd_up_r, rd_lo_r;

  // stage 1: window update and store write
  logic          s1_v_r;
  logic [23:0]   s1_pix_r;
  logic [CW-1:0] s1_idx_r;
  bb3_flags_t    s1_fl_r;
  logic          s1_hz_r;
  logic [23:0]   byp_up_r, byp_lo_r;

  // stage 2: sums
  logic          s2_v_r;
  bb3_flags_t    s2_fl_r;
  logic [11:0]   s2_sum_r [3];

  logic [23:0] win_r [9];
  logic [23:0] win_nxt [9];
  logic [23:0] up_eff, lo_eff;
  logic [11:0] sum [3];

  logic [2:0]  out_cnt;
  logic [24:0] out_head;
  logic        out_push, out_pop;

  assign cmd_pop = cmd_valid &&
                   ((5'(out_cnt) + 5'(s1_v_r) + 5'(s2_v_r)) < 5'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      mem_up[s1_idx_r] <= lo_eff;
      mem_lo[s1_idx_r] <= s1_pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      rd_up_r <= mem_up[cmd_idx];
      rd_lo_r <= mem_lo[cmd_idx];
    end
  end

  // a read in the same cycle as the write of the same column sees old data
  always_comb begin
    up_eff = s1_hz_r ? byp_up_r : rd_up_r;
    lo_eff = s1_hz_r ? byp_lo_r : rd_lo_r;
    for (int r = 0; r < 3; r++) begin
      win_nxt[r*3]   = win_r[r*3+1];
      win_nxt[r*3+1] = win_r[r*3+2];
    end
    win_nxt[2] = up_eff;
    win_nxt[5] = lo_eff;
    win_nxt[8] = s1_pix_r;
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum[k] = 12'd0;
      for (int i = 0; i < 9; i++) begin
        if (!((i < 3 && !s1_fl_r.top) || (i > 5 && !s1_fl_r.bottom) ||
              (i % 3 == 0 && !s1_fl_r.left) || (i % 3 == 2 && !s1_fl_r.right))) begin
          sum[k] = sum[k] + 12'(win_nxt[i][23-8*k -: 8]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      for (int i = 0; i < 9; i++) win_r[i] <= 24'd0;
    end else begin
      s1_v_r <= cmd_pop;
      s2_v_r <= s1_v_r && s1_fl_r.emit;
      if (s1_v_r) begin
        for (int i = 0; i < 9; i++) win_r[i] <= win_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      s1_pix_r <= cmd_pix;
      s1_idx_r <= cmd_idx;
      s1_fl_r  <= cmd_flags;
      s1_hz_r  <= s1_v_r && (s1_idx_r == cmd_idx);
    end
    if (s1_v_r) begin
      byp_up_r <= lo_eff;
      byp_lo_r <= s1_pix_r;
      s2_fl_r  <= s1_fl_r;
      for (int k = 0; k < 3; k++) s2_sum_r[k] <= sum[k];
    end
  end

  assign out_push = s2_v_r;
  assign out_pop  = out_valid && out_ready;

  bb3_fifo #(.W(25), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (out_push),
    .push_data ({div_avg(s2_sum_r[0], s2_fl_r.top & s2_fl_r.bottom,
                         s2_fl_r.left & s2_fl_r.right),
                 div_avg(s2_sum_r[1], s2_fl_r.top & s2_fl_r.bottom,
                         s2_fl_r.left & s2_fl_r.right),
                 div_avg(s2_sum_r[2], s2_fl_r.top & s2_fl_r.bottom,
                         s2_fl_r.left & s2_fl_r.right),
                 s2_fl_r.last}),
    .pop       (out_pop),
    .head      (out_head),
    .count     (out_cnt)
  );

  assign out_valid     = out_cnt != 3'd0;
  assign out_red       = out_head[24:17];
  assign out_green     = out_head[16:9];
  assign out_blue      = out_head[8:1];
  assign out_last      = out_head[0];
  assign stat.out_cnt  = out_cnt;
  assign stat.inflight = 2'(s1_v_r) + 2'(s2_v_r);
endmodule

@@ rtl/core/box_blur_3x3_edge_aware_top.sv @@
// result: out_valid rises once the item that completes its neighbourhood
//   (one row plus one pixel later in the stream) is in the result queue
// throughput: one item per cycle while the command and result queues have room
// reset: synchronous active low; clears counters, queues and window, sizes
//   return to 640 x 480; line store contents stay undefined until written
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_aware_top
// streaming edge-aware 3x3 rgb box blur with front classifier and back datapath
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_aware_top #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [12:0] cfg_wdata,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [7:0]  in_red_in,
  input  logic [7:0]  in_green_in,
  input  logic [7:0]  in_blue_in,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red_out,
  output logic [7:0]  out_green_out,
  output logic [7:0]  out_blue_out,
  output logic        out_frame_end
);
  import bb3_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned CMD_W = 24 + CW + $bits(bb3_flags_t);

  // size registers
  logic [10:0] width_r;
  logic [12:0] height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 11'd640;
      height_r <= 13'd480;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_WIDTH:  width_r  <= cfg_wdata[10:0];
        REG_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // front end: counters and per item classification
  logic          accept, f_push;
  logic [23:0]   f_pix;
  logic [CW-1:0] f_idx;
  bb3_flags_t    f_flags;

  assign accept = in_valid && in_ready;

  bb3_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .width_cfg  (width_r),
    .height_cfg (height_r),
    .accept     (accept),
    .req_type   (in_req_type),
    .pix_in     ({in_red_in, in_green_in, in_blue_in}),
    .push       (f_push),
    .pix_out    (f_pix),
    .idx_out    (f_idx),
    .flags_out  (f_flags)
  );

  // command queue between the two halves; ignored drains never enter it
  logic [CMD_W-1:0]          q_head;
  logic [$clog2(CMD_DEPTH):0] q_cnt;
  logic                      q_pop;

  bb3_fifo #(.W(CMD_W), .DEPTH(CMD_DEPTH)) u_cmd_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_data ({f_pix, f_idx, f_flags}),
    .pop       (q_pop),
    .head      (q_head),
    .count     (q_cnt)
  );

  // a transfer is taken whenever the command queue has room
  assign in_ready = q_cnt < ($clog2(CMD_DEPTH)+1)'(CMD_DEPTH);

  // back end: line stores, window, sums, division, result queue
  bb3_stat_t b_stat;

  bb3_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_cnt != '0),
    .cmd_pix   (q_head[CMD_W-1 -: 24]),
    .cmd_idx   (q_head[$bits(bb3_flags_t) +: CW]),
    .cmd_flags (bb3_flags_t'(q_head[$bits(bb3_flags_t)-1:0])),
    .cmd_pop   (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_red   (out_red_out),
    .out_green (out_green_out),
    .out_blue  (out_blue_out),
    .out_last  (out_frame_end),
    .stat      (b_stat)
  );

  // result queue plus items in flight never exceed its depth
  a_out_credit: assert property (@(posedge clk) disable iff (!rst_n)
    (4'(b_stat.out_cnt) + 4'(b_stat.inflight)) <= 4'd4)
    else $error("result queue overcommitted");

  // command queue never overfills
  a_cmd_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt <= ($clog2(CMD_DEPTH)+1)'(CMD_DEPTH))
    else $error("command queue overflow");

  // the back end never pops an empty command queue
  a_no_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (q_cnt != '0))
    else $error("pop from empty command queue");
endmodule
